// ===== rtl/core/hfs_pkg.sv =====
// ----------------------------------------------------------------------------
// hfs_pkg: shared definitions for the two-state scaled forward step
// Default widths, reset values, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package hfs_pkg;

    // default formats: probabilities Q1.15, likelihoods 24 bits (16 fraction)
    localparam int PROB_FRAC_BITS_DEF = 15;
    localparam int LIKE_WIDTH_DEF     = 24;

    // reciprocal output width, Q16.16; also the number of division steps
    localparam int SCALE_W = 32;

    // reset value of the initial pair and of the held pair
    localparam int ALPHA_RST = 16384;

    // configuration register indexes
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_IDX_NULL = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_IDX_ALT  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the transaction, apply start load
        logic mul;     // alpha times transition products
        logic psum;    // sum products per destination state
        logic ulik;    // multiply by the emission likelihoods
        logic ssum;    // form the unnormalized sum
        logic dinit;   // seed the division lanes
        logic dstep;   // one restoring division step
        logic finish;  // round, load the output register, update state
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic zero;    // unnormalized sum is zero
        logic last;    // final division step this cycle
    } t_sts;

endpackage

// ===== rtl/core/hfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// hfs_ctrl: sequencer of the forward step
// Walks one transaction through the product, sum and division phases and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module hfs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output hfs_pkg::t_cmd o_cmd,
    input  hfs_pkg::t_sts i_sts
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_PSUM  = 8'b0000_0100,
        S_ULIK  = 8'b0000_1000,
        S_SSUM  = 8'b0001_0000,
        S_DINIT = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PSUM;
            end
            S_PSUM: begin
                o_cmd.psum = 1'b1;
                n_state    = S_ULIK;
            end
            S_ULIK: begin
                o_cmd.ulik = 1'b1;
                n_state    = S_SSUM;
            end
            S_SSUM: begin
                o_cmd.ssum = 1'b1;
                n_state    = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.dinit = 1'b1;
                // skip the division when there is nothing to normalize
                n_state     = i_sts.zero ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.dstep = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/hfs_dpath.sv =====
// ----------------------------------------------------------------------------
// hfs_dpath: arithmetic of the forward step
// Held pair and configuration registers, product and sum registers, three
// restoring division lanes (two normalized probabilities and the
// reciprocal) and the output register.
// ----------------------------------------------------------------------------
module hfs_dpath #(
    parameter int PROB_FRAC_BITS = hfs_pkg::PROB_FRAC_BITS_DEF,
    parameter int LIKE_WIDTH     = hfs_pkg::LIKE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hfs_pkg::t_cmd               i_cmd,
    output hfs_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic [hfs_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [PROB_FRAC_BITS:0]     i_cfg_wdata,
    input  logic                        i_start_req,
    input  logic [PROB_FRAC_BITS:0]     i_trans_null_to_null,
    input  logic [PROB_FRAC_BITS:0]     i_trans_alt_to_null,
    input  logic [PROB_FRAC_BITS:0]     i_trans_null_to_alt,
    input  logic [PROB_FRAC_BITS:0]     i_trans_alt_to_alt,
    input  logic [LIKE_WIDTH-1:0]       i_like_null,
    input  logic [LIKE_WIDTH-1:0]       i_like_alt,
    output logic [PROB_FRAC_BITS:0]     o_alpha_null_out,
    output logic [PROB_FRAC_BITS:0]     o_alpha_alt_out,
    output logic [hfs_pkg::SCALE_W-1:0] o_scale,
    output logic                        o_zero_sum
);

    localparam int F   = PROB_FRAC_BITS;
    localparam int PW  = F + 1;
    localparam int MW  = 2 * PW;          // probability product
    localparam int PSW = MW + 1;          // sum of two products
    localparam int UW  = PSW + LIKE_WIDTH; // times likelihood
    localparam int SW  = UW + 1;          // unnormalized sum
    localparam int RW  = SW + 1;          // division remainder
    localparam int SCW = hfs_pkg::SCALE_W;
    localparam int CW  = $clog2(SCW);

    // 1.0 in the format of a probability product; the reciprocal saturates when the sum is at or below it
    localparam logic [SW-1:0] S_ONE = {{(SW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};

    logic [PW-1:0]  r_cfg_null, r_cfg_alt;
    logic [PW-1:0]  r_prev_null, r_prev_alt;
    logic [PW-1:0]  r_t00, r_t10, r_t01, r_t11;
    logic [LIKE_WIDTH-1:0] r_l0, r_l1;
    logic [MW-1:0]  r_m00, r_m10, r_m01, r_m11;
    logic [PSW-1:0] r_p0, r_p1;
    logic [UW-1:0]  r_u0, r_u1;
    logic [SW-1:0]  r_s;
    logic           r_sat;
    logic [RW-1:0]  r_r0, r_r1, r_rs;
    logic [PW-1:0]  r_q0, r_q1;
    logic [SCW-1:0] r_qs;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  r_o_null, r_o_alt;
    logic [SCW-1:0] r_o_scale;
    logic           r_o_zero;

    logic [RW-1:0]  div_s;
    logic           ge0, ge1, ges;
    logic [RW-1:0]  nr0, nr1, nrs;
    logic           alpha_en;
    logic           zero;
    logic [PW:0]    rnd0, rnd1;
    logic [SCW:0]   rnds;

    // one compare-subtract per lane; remainder stays below the divisor
    always_comb begin
        div_s    = {1'b0, r_s};
        ge0      = (r_r0 >= div_s);
        ge1      = (r_r1 >= div_s);
        ges      = (r_rs >= div_s);
        nr0      = ge0 ? (r_r0 - div_s) : r_r0;
        nr1      = ge1 ? (r_r1 - div_s) : r_r1;
        nrs      = ges ? (r_rs - div_s) : r_rs;
        alpha_en = (r_cnt < CW'(PW));
        zero     = (r_s == '0);
        // round to nearest, ties up: the remainder is already doubled
        rnd0     = {1'b0, r_q0} + (PW+1)'(ge0);
        rnd1     = {1'b0, r_q1} + (PW+1)'(ge1);
        rnds     = {1'b0, r_qs} + (SCW+1)'(ges);
    end

    assign o_sts.zero = zero;
    assign o_sts.last = (r_cnt == CW'(SCW - 1));

    // configuration, held pair and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_null  <= PW'(hfs_pkg::ALPHA_RST);
            r_cfg_alt   <= PW'(hfs_pkg::ALPHA_RST);
            r_prev_null <= PW'(hfs_pkg::ALPHA_RST);
            r_prev_alt  <= PW'(hfs_pkg::ALPHA_RST);
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    hfs_pkg::CFG_IDX_NULL: r_cfg_null <= i_cfg_wdata;
                    hfs_pkg::CFG_IDX_ALT:  r_cfg_alt  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.load && i_start_req) begin
                r_prev_null <= r_cfg_null;
                r_prev_alt  <= r_cfg_alt;
            end else if (i_cmd.finish && !zero) begin
                r_prev_null <= rnd0[PW-1:0];
                r_prev_alt  <= rnd1[PW-1:0];
            end
            if (i_cmd.dinit) begin
                r_cnt <= '0;
            end else if (i_cmd.dstep) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t00 <= i_trans_null_to_null;
            r_t10 <= i_trans_alt_to_null;
            r_t01 <= i_trans_null_to_alt;
            r_t11 <= i_trans_alt_to_alt;
            r_l0  <= i_like_null;
            r_l1  <= i_like_alt;
        end
        if (i_cmd.mul) begin
            r_m00 <= {{PW{1'b0}}, r_prev_null} * {{PW{1'b0}}, r_t00};
            r_m10 <= {{PW{1'b0}}, r_prev_alt}  * {{PW{1'b0}}, r_t10};
            r_m01 <= {{PW{1'b0}}, r_prev_null} * {{PW{1'b0}}, r_t01};
            r_m11 <= {{PW{1'b0}}, r_prev_alt}  * {{PW{1'b0}}, r_t11};
        end
        if (i_cmd.psum) begin
            r_p0 <= {1'b0, r_m00} + {1'b0, r_m10};
            r_p1 <= {1'b0, r_m01} + {1'b0, r_m11};
        end
        if (i_cmd.ulik) begin
            r_u0 <= {{LIKE_WIDTH{1'b0}}, r_p0} * {{PSW{1'b0}}, r_l0};
            r_u1 <= {{LIKE_WIDTH{1'b0}}, r_p1} * {{PSW{1'b0}}, r_l1};
        end
        if (i_cmd.ssum) begin
            r_s <= {1'b0, r_u0} + {1'b0, r_u1};
        end
        if (i_cmd.dinit) begin
            // probability lanes start on u itself (u <= s, integer bit first);
            // reciprocal lane starts on 2 * 1.0, first step already shifted
            r_r0  <= {2'b00, r_u0};
            r_r1  <= {2'b00, r_u1};
            r_rs  <= {S_ONE, 1'b0};
            r_q0  <= '0;
            r_q1  <= '0;
            r_qs  <= '0;
            r_sat <= (r_s <= S_ONE);
        end
        if (i_cmd.dstep) begin
            if (alpha_en) begin
                r_r0 <= {nr0[RW-2:0], 1'b0};
                r_r1 <= {nr1[RW-2:0], 1'b0};
                r_q0 <= {r_q0[PW-2:0], ge0};
                r_q1 <= {r_q1[PW-2:0], ge1};
            end
            r_rs <= {nrs[RW-2:0], 1'b0};
            r_qs <= {r_qs[SCW-2:0], ges};
        end
        if (i_cmd.finish) begin
            r_o_zero <= zero;
            if (zero) begin
                r_o_null  <= r_prev_null;
                r_o_alt   <= r_prev_alt;
                r_o_scale <= '1;
            end else begin
                r_o_null  <= rnd0[PW-1:0];
                r_o_alt   <= rnd1[PW-1:0];
                r_o_scale <= (r_sat || rnds[SCW]) ? '1 : rnds[SCW-1:0];
            end
        end
    end

    assign o_alpha_null_out = r_o_null;
    assign o_alpha_alt_out  = r_o_alt;
    assign o_scale          = r_o_scale;
    assign o_zero_sum       = r_o_zero;

endmodule

// ===== rtl/core/two_state_hmm_forward_step_core.sv =====
// ----------------------------------------------------------------------------
// two_state_hmm_forward_step_core: scaled forward step of a two-state HMM
// Takes one step's transition matrix and emission likelihoods, advances
// the held normalized forward pair and reports the pair and the reciprocal
// of the unnormalized sum.
//
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid/tready           tdata: transitions, likelihoods
//                                              tuser: start_req
// m_axis    out        tvalid/tready           tdata: pair, scale
//                                              tuser: zero_sum
// cfg       in         i_cfg_we (no stall)     i_cfg_addr, i_cfg_wdata
//
// Sequence: accept, the product and sum phases and division seeding, the
//   division steps, then round and load; a zero sum skips the division.
//   The reciprocal lane sets the length of the division phase: it retires
//   one quotient bit per cycle for SCALE_W bits.
// Reset: i_rst_n is synchronous, active low; the initial pair registers and
//   the held pair return to 16384, no output is pending.
// Stalls: the output register holds a finished result while the next
//   transaction is accepted and computed; only the final load waits on
//   m_axis_tready.
// ----------------------------------------------------------------------------
module two_state_hmm_forward_step_core #(
    parameter int PROB_FRAC_BITS = hfs_pkg::PROB_FRAC_BITS_DEF,
    parameter int LIKE_WIDTH     = hfs_pkg::LIKE_WIDTH_DEF,
    localparam int PW  = PROB_FRAC_BITS + 1,
    localparam int ID  = 4 * PW + 2 * LIKE_WIDTH,
    localparam int IDW = ((ID + 7) / 8) * 8,
    localparam int OD  = 2 * PW + hfs_pkg::SCALE_W,
    localparam int ODW = ((OD + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // from bit 0: trans_null_to_null, trans_alt_to_null, trans_null_to_alt,
    // trans_alt_to_alt, like_null, like_alt, zero fill
    input  logic [IDW-1:0]             s_axis_tdata,
    // start_req
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // from bit 0: alpha_null_out, alpha_alt_out, scale, zero fill
    output logic [ODW-1:0]             m_axis_tdata,
    // zero_sum
    output logic                       m_axis_tuser,
    input  logic                       i_cfg_we,
    input  logic [hfs_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [PW-1:0]              i_cfg_wdata
);

    localparam int LW  = LIKE_WIDTH;
    localparam int SCW = hfs_pkg::SCALE_W;

    hfs_pkg::t_cmd cmd;
    hfs_pkg::t_sts sts;

    logic [PW-1:0]  alpha_null_out, alpha_alt_out;
    logic [SCW-1:0] scale;

    // sequencer: accept, phase commands, output valid
    hfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // datapath: unpack the transaction fields straight from tdata
    hfs_dpath #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS),
        .LIKE_WIDTH     (LIKE_WIDTH)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_addr           (i_cfg_addr),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_start_req          (s_axis_tuser),
        .i_trans_null_to_null (s_axis_tdata[0      +: PW]),
        .i_trans_alt_to_null  (s_axis_tdata[PW     +: PW]),
        .i_trans_null_to_alt  (s_axis_tdata[2*PW   +: PW]),
        .i_trans_alt_to_alt   (s_axis_tdata[3*PW   +: PW]),
        .i_like_null          (s_axis_tdata[4*PW   +: LW]),
        .i_like_alt           (s_axis_tdata[4*PW+LW +: LW]),
        .o_alpha_null_out     (alpha_null_out),
        .o_alpha_alt_out      (alpha_alt_out),
        .o_scale              (scale),
        .o_zero_sum           (m_axis_tuser)
    );

    // pack the result, zero fill to whole bytes
    assign m_axis_tdata = ODW'({scale, alpha_alt_out, alpha_null_out});

    // one transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("transaction accepted while another is in flight");

    // a zero sum always reports a saturated reciprocal
    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (scale == '1))
        else $error("zero sum without saturated scale");

    // normalized outputs never exceed 1.0
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        ((alpha_null_out <= (PW'(1) << PROB_FRAC_BITS)) &&
         (alpha_alt_out  <= (PW'(1) << PROB_FRAC_BITS))))
        else $error("normalized probability above one");

endmodule
